>>> hdl/ptrc_pkg.sv
// Shared types and constants of the pre-trade risk checker.
// Used by every module of the block; depends on nothing.
package ptrc_pkg;

  localparam int SYMBOLS     = 16;
  localparam int ORDER_SLOTS = 64;
  localparam int SYM_W   = $clog2(SYMBOLS);
  localparam int SLOT_W  = $clog2(ORDER_SLOTS);
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);

  localparam logic [2:0] ACT_CHECK  = 3'd0;
  localparam logic [2:0] ACT_UPDATE = 3'd1;
  localparam logic [2:0] ACT_FILL   = 3'd2;
  localparam logic [2:0] ACT_TICK   = 3'd3;
  localparam logic [2:0] ACT_DAY    = 3'd4;

  localparam logic [2:0] RC_NONE   = 3'd0;
  localparam logic [2:0] RC_VOLUME = 3'd1;
  localparam logic [2:0] RC_SIZE   = 3'd2;
  localparam logic [2:0] RC_TRADED = 3'd3;
  localparam logic [2:0] RC_FLOW   = 3'd4;
  localparam logic [2:0] RC_ACTIVE = 3'd5;
  localparam logic [2:0] RC_CANCEL = 3'd6;
  localparam logic [2:0] RC_SELF   = 3'd7;

  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_SIZE   = 3'd1;
  localparam logic [2:0] REG_TRADED = 3'd2;
  localparam logic [2:0] REG_FLOW   = 3'd3;
  localparam logic [2:0] REG_WINDOW = 3'd4;
  localparam logic [2:0] REG_ACTIVE = 3'd5;
  localparam logic [2:0] REG_CANCEL = 3'd6;
  localparam logic [2:0] REG_GUARD  = 3'd7;

  typedef struct packed {
    logic [2:0]        action;
    logic [SYM_W-1:0]  symbol;
    logic [SLOT_W-1:0] order_slot;
    logic              side;
    logic [31:0]       price;
    logic signed [31:0] volume;
    logic              order_live;
    logic              order_cancelled;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] reject_code;
    logic       was_check;
  } out_item_t;

  typedef struct packed {
    logic        checks_enabled;
    logic [30:0] max_order_volume;
    logic [31:0] trade_volume_limit;
    logic [15:0] flow_limit;
    logic [15:0] flow_window_ticks;
    logic [6:0]  max_active_orders;
    logic [15:0] cancel_limit;
    logic        self_trade_guard;
  } cfg_t;

endpackage

>>> hdl/ptrc_front.sv
// Front end: takes requests and holds them in a short queue for the back end.
// Depends on ptrc_pkg.
module ptrc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_start,
  input  ptrc_pkg::in_item_t in_item,
  output logic               in_busy,
  input  logic               q_pop,
  output logic               q_valid,
  output ptrc_pkg::in_item_t q_item
);
  import ptrc_pkg::*;

  in_item_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;
  logic              push;

  assign in_busy = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign push    = in_start && !in_busy;
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
    end
  end
endmodule

>>> hdl/ptrc_back.sv
// Back end: runs the rules, the slot scan and the state updates of one request.
// Depends on ptrc_pkg.
module ptrc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ptrc_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  ptrc_pkg::in_item_t  q_item,
  output logic                q_pop,
  output logic                out_valid,
  output ptrc_pkg::out_item_t out_item
);
  import ptrc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        st_r, st_nxt;
  in_item_t          cur_r;
  logic [SLOT_W-1:0] idx_r;
  logic              found_r;
  logic [31:0]       best_r;

  logic [ORDER_SLOTS-1:0] slot_valid_r;
  logic              slot_side_r  [ORDER_SLOTS];
  logic [SYM_W-1:0]  slot_sym_r   [ORDER_SLOTS];
  logic [31:0]       slot_price_r [ORDER_SLOTS];
  logic              rd_side_r;
  logic [SYM_W-1:0]  rd_sym_r;
  logic [31:0]       rd_price_r;
  logic [SLOT_W-1:0] rd_addr;
  logic [6:0]        active_r     [SYMBOLS];
  logic [15:0]       cancels_r    [SYMBOLS];
  logic [31:0]       traded_r;
  logic [15:0]       flow_count_r, flow_timer_r;

  logic [2:0]  pre_code;
  logic [32:0] sum;
  logic        hit;
  logic [15:0] tick_nxt;
  logic        self_rej;

  always_comb begin
    pre_code = RC_NONE;
    if (q_item.volume <= 0) pre_code = RC_VOLUME;
    else if ($unsigned(q_item.volume) > {1'b0, cfg.max_order_volume}) pre_code = RC_SIZE;
    else if (traded_r >= cfg.trade_volume_limit) pre_code = RC_TRADED;
    else if (flow_count_r >= cfg.flow_limit) pre_code = RC_FLOW;
    else if (active_r[q_item.symbol] >= cfg.max_active_orders) pre_code = RC_ACTIVE;
    else if (cancels_r[q_item.symbol] >= cfg.cancel_limit) pre_code = RC_CANCEL;
  end

  // The slot store has a registered read: the scan fetches one slot ahead of idx_r,
  // and an update fetches its slot while it is taken from the queue.
  assign rd_addr = (st_r == ST_SCAN) ? idx_r + 1'b1 :
                   (q_item.action == ACT_CHECK) ? '0 : q_item.order_slot;

  assign hit = slot_valid_r[idx_r] && rd_sym_r == cur_r.symbol &&
               rd_side_r != cur_r.side;
  assign self_rej = (best_r != '0) &&
                    (cur_r.side ? (cur_r.price <= best_r) : (cur_r.price >= best_r));
  assign sum = cur_r.volume[31] ? ({1'b0, traded_r} - {1'b0, -cur_r.volume})
                                : ({1'b0, traded_r} + {1'b0, cur_r.volume});
  assign tick_nxt = (flow_timer_r == 16'hFFFF) ? flow_timer_r : flow_timer_r + 16'd1;
  assign q_pop = (st_r == ST_IDLE) && q_valid;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (q_valid) begin
        if (q_item.action == ACT_CHECK && cfg.checks_enabled && pre_code == RC_NONE &&
            cfg.self_trade_guard) st_nxt = ST_SCAN;
        else st_nxt = ST_DONE;
      end
      ST_SCAN: if (idx_r == SLOT_W'(ORDER_SLOTS-1)) st_nxt = ST_DONE;
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_item;
    if (st_r == ST_SCAN && hit) begin
      if (!found_r || (cur_r.side == 1'b0 ? rd_price_r < best_r
                                          : rd_price_r > best_r))
        best_r <= rd_price_r;
    end else if (q_pop) begin
      best_r <= '0;
    end
    rd_side_r  <= slot_side_r[rd_addr];
    rd_sym_r   <= slot_sym_r[rd_addr];
    rd_price_r <= slot_price_r[rd_addr];
    if (st_r == ST_DONE && cur_r.action == ACT_UPDATE && cur_r.order_live) begin
      slot_side_r[cur_r.order_slot]  <= cur_r.side;
      slot_sym_r[cur_r.order_slot]   <= cur_r.symbol;
      slot_price_r[cur_r.order_slot] <= cur_r.price;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      idx_r        <= '0;
      found_r      <= 1'b0;
      out_valid    <= 1'b0;
      out_item     <= '0;
      traded_r     <= '0;
      flow_count_r <= '0;
      flow_timer_r <= '0;
      slot_valid_r <= '0;
      for (int i = 0; i < SYMBOLS; i++) begin
        active_r[i]  <= '0;
        cancels_r[i] <= '0;
      end
    end else begin
      st_r      <= st_nxt;
      out_valid <= 1'b0;
      if (q_pop) begin
        idx_r   <= '0;
        found_r <= 1'b0;
        if (q_item.action == ACT_CHECK && cfg.checks_enabled && pre_code != RC_NONE)
          out_item <= '{accepted: 1'b0, reject_code: pre_code, was_check: 1'b1};
        else
          out_item <= '{accepted: 1'b1, reject_code: RC_NONE,
                        was_check: (q_item.action == ACT_CHECK)};
      end
      if (st_r == ST_SCAN) begin
        idx_r <= idx_r + 1'b1;
        if (hit) found_r <= 1'b1;
      end
      if (st_r == ST_DONE) begin
        out_valid <= 1'b1;
        case (cur_r.action)
          ACT_CHECK: begin
            if (cfg.checks_enabled && out_item.accepted) begin
              if (cfg.self_trade_guard && self_rej) begin
                out_item <= '{accepted: 1'b0, reject_code: RC_SELF, was_check: 1'b1};
              end else if (flow_count_r != 16'hFFFF) begin
                flow_count_r <= flow_count_r + 16'd1;
              end
            end
          end
          ACT_UPDATE: begin
            if (slot_valid_r[cur_r.order_slot]) begin
              if (!(cur_r.order_live && rd_sym_r == cur_r.symbol) &&
                  active_r[rd_sym_r] != 7'd0)
                active_r[rd_sym_r] <= active_r[rd_sym_r] - 7'd1;
            end
            slot_valid_r[cur_r.order_slot] <= cur_r.order_live;
            if (cur_r.order_live) begin
              if (slot_valid_r[cur_r.order_slot] && rd_sym_r == cur_r.symbol) begin
                if (active_r[cur_r.symbol] == 7'd0) active_r[cur_r.symbol] <= 7'd1;
              end else if (active_r[cur_r.symbol] != 7'd127) begin
                active_r[cur_r.symbol] <= active_r[cur_r.symbol] + 7'd1;
              end
            end
            if (cur_r.order_cancelled && cancels_r[cur_r.symbol] != 16'hFFFF)
              cancels_r[cur_r.symbol] <= cancels_r[cur_r.symbol] + 16'd1;
          end
          ACT_FILL: begin
            if (sum[32]) traded_r <= cur_r.volume[31] ? 32'd0 : 32'hFFFF_FFFF;
            else traded_r <= sum[31:0];
          end
          ACT_TICK: begin
            if (tick_nxt >= cfg.flow_window_ticks) begin
              flow_count_r <= '0;
              flow_timer_r <= '0;
            end else begin
              flow_timer_r <= tick_nxt;
            end
          end
          ACT_DAY: begin
            traded_r     <= '0;
            flow_count_r <= '0;
            flow_timer_r <= '0;
            slot_valid_r <= '0;
            for (int i = 0; i < SYMBOLS; i++) begin
              active_r[i]  <= '0;
              cancels_r[i] <= '0;
            end
          end
          default: ;
        endcase
      end
    end
  end
endmodule

>>> hdl/ptrc_regs.sv
// Configuration register file on the APB-style port.
// Depends on ptrc_pkg.
module ptrc_regs (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output ptrc_pkg::cfg_t cfg
);
  import ptrc_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign cfg    = cfg_r;
  assign ridx   = paddr[4:2];

  always_comb begin
    case (ridx)
      REG_ENABLE: prdata = {31'd0, cfg_r.checks_enabled};
      REG_SIZE:   prdata = {1'b0, cfg_r.max_order_volume};
      REG_TRADED: prdata = cfg_r.trade_volume_limit;
      REG_FLOW:   prdata = {16'd0, cfg_r.flow_limit};
      REG_WINDOW: prdata = {16'd0, cfg_r.flow_window_ticks};
      REG_ACTIVE: prdata = {25'd0, cfg_r.max_active_orders};
      REG_CANCEL: prdata = {16'd0, cfg_r.cancel_limit};
      REG_GUARD:  prdata = {31'd0, cfg_r.self_trade_guard};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{checks_enabled: 1'b0, max_order_volume: 31'd100,
                 trade_volume_limit: 32'd1000, flow_limit: 16'd50,
                 flow_window_ticks: 16'd1, max_active_orders: 7'd50,
                 cancel_limit: 16'd500, self_trade_guard: 1'b0};
    end else if (psel && penable && pwrite && pready) begin
      case (ridx)
        REG_ENABLE: cfg_r.checks_enabled     <= pwdata[0];
        REG_SIZE:   cfg_r.max_order_volume   <= pwdata[30:0];
        REG_TRADED: cfg_r.trade_volume_limit <= pwdata;
        REG_FLOW:   cfg_r.flow_limit         <= pwdata[15:0];
        REG_WINDOW: cfg_r.flow_window_ticks  <= pwdata[15:0];
        REG_ACTIVE: cfg_r.max_active_orders  <= pwdata[6:0];
        REG_CANCEL: cfg_r.cancel_limit       <= pwdata[15:0];
        REG_GUARD:  cfg_r.self_trade_guard   <= pwdata[0];
        default: ;
      endcase
    end
  end
endmodule

>>> hdl/pre_trade_risk_checker.sv
// Top level of the pre-trade risk checker: register file, front queue, back end.
// Depends on ptrc_pkg, ptrc_regs, ptrc_front and ptrc_back.
//
// A request is taken when in_start is high and in_busy is low. It is one of an
// order check, an order update, a trade fill, a timer tick or a daily reset.
// Every request yields one result on out_item, shown for one cycle with
// out_valid; the receiver cannot stall it.
// A front queue of two entries takes requests while the back end works.
// A non-check request, or a check that fails a plain rule or runs with checks or
// self-trade prevention off, goes from the idle state straight to the done state.
// A check that passes the plain rules with checks and self-trade prevention on
// scans the 64 order slots, one slot per cycle; sustained rate is set by that scan.
// The user must write configuration over the cfg_ port while the block is idle; the block does not enforce it.
// Reset clears all counters, slots and queue and loads the register defaults.
module pre_trade_risk_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_start,
  input  ptrc_pkg::in_item_t  in_item,
  output logic                in_busy,
  output logic                out_valid,
  output ptrc_pkg::out_item_t out_item,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [4:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import ptrc_pkg::*;

  cfg_t     cfg;
  logic     q_valid, q_pop;
  in_item_t q_item;

  ptrc_regs u_regs (
    .clk, .rst_n, .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .pready(cfg_pready), .cfg
  );

  ptrc_front u_front (
    .clk, .rst_n, .in_start, .in_item, .in_busy, .q_pop, .q_valid, .q_item
  );

  ptrc_back u_back (
    .clk, .rst_n, .cfg, .q_valid, .q_item, .q_pop, .out_valid, .out_item
  );
endmodule

>>> hdl/ptrc_checker.sv
// Port-level assertions for the pre-trade risk checker and their bind.
// Depends on ptrc_pkg and pre_trade_risk_checker.
module ptrc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input ptrc_pkg::out_item_t out_item,
  input logic                cfg_pready
);
  import ptrc_pkg::*;

  a_acc_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.accepted == (out_item.reject_code == RC_NONE)))
    else $error("accepted and reject code disagree");

  a_rej_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.accepted |-> out_item.was_check)
    else $error("rejection on a non-check request");

  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results in adjacent cycles");

  a_ready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");
endmodule

bind pre_trade_risk_checker ptrc_checker u_checker (
  .clk, .rst_n, .out_valid, .out_item, .cfg_pready
);

>>> tb/pre_trade_risk_checker_chk.sv
// Checker for the pre-trade risk checker: watches requests, registers and results,
// predicts each result and compares it. Depends on ptrc_pkg.
`timescale 1ns / 100ps
module pre_trade_risk_checker_chk (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_start,
  input  ptrc_pkg::in_item_t  in_item,
  input  logic                in_busy,
  input  logic                out_valid,
  input  ptrc_pkg::out_item_t out_item,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic                cfg_pready,
  input  logic [4:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output int                  fail_count,
  output int                  pending_count
);
  import ptrc_pkg::*;

  cfg_t        regs;
  logic        slot_valid [ORDER_SLOTS];
  logic        slot_side  [ORDER_SLOTS];
  logic [3:0]  slot_sym   [ORDER_SLOTS];
  logic [31:0] slot_price [ORDER_SLOTS];
  logic [6:0]  active_cnt [SYMBOLS];
  logic [15:0] cancel_cnt [SYMBOLS];
  logic [31:0] traded;
  logic [15:0] flow_cnt, flow_tmr;
  out_item_t   verdicts [$];

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic clear_day();
    for (int i = 0; i < ORDER_SLOTS; i++) slot_valid[i] = 1'b0;
    for (int i = 0; i < SYMBOLS; i++) begin
      active_cnt[i] = '0;
      cancel_cnt[i] = '0;
    end
    traded = '0;
    flow_cnt = '0;
    flow_tmr = '0;
  endtask

  function automatic logic [2:0] check_order(input in_item_t r);
    logic [31:0] best;
    logic        found;
    best = '0;
    found = 1'b0;
    if (r.volume <= 0) return RC_VOLUME;
    if ($unsigned(r.volume) > {1'b0, regs.max_order_volume}) return RC_SIZE;
    if (traded >= regs.trade_volume_limit) return RC_TRADED;
    if (flow_cnt >= regs.flow_limit) return RC_FLOW;
    if (active_cnt[r.symbol] >= regs.max_active_orders) return RC_ACTIVE;
    if (cancel_cnt[r.symbol] >= regs.cancel_limit) return RC_CANCEL;
    if (regs.self_trade_guard) begin
      for (int i = 0; i < ORDER_SLOTS; i++) begin
        if (slot_valid[i] && slot_sym[i] == r.symbol && slot_side[i] != r.side) begin
          if (!found) begin
            best = slot_price[i];
            found = 1'b1;
          end else if (r.side == 1'b0 ? slot_price[i] < best : slot_price[i] > best) begin
            best = slot_price[i];
          end
        end
      end
      if (best > 0) begin
        if (r.side == 1'b0 && r.price >= best) return RC_SELF;
        if (r.side == 1'b1 && r.price <= best) return RC_SELF;
      end
    end
    if (flow_cnt != 16'hFFFF) flow_cnt++;
    return RC_NONE;
  endfunction

  task automatic apply_request(input in_item_t r);
    out_item_t   v;
    logic [2:0]  code;
    longint      t;
    code = RC_NONE;
    v.was_check = 1'b0;
    case (r.action)
      ACT_CHECK: begin
        v.was_check = 1'b1;
        if (regs.checks_enabled) code = check_order(r);
      end
      ACT_UPDATE: begin
        if (slot_valid[r.order_slot]) begin
          if (active_cnt[slot_sym[r.order_slot]] > 0) active_cnt[slot_sym[r.order_slot]]--;
          slot_valid[r.order_slot] = 1'b0;
        end
        if (r.order_live) begin
          slot_valid[r.order_slot] = 1'b1;
          slot_side[r.order_slot]  = r.side;
          slot_sym[r.order_slot]   = r.symbol;
          slot_price[r.order_slot] = r.price;
          if (active_cnt[r.symbol] != 7'd127) active_cnt[r.symbol]++;
        end
        if (r.order_cancelled && cancel_cnt[r.symbol] != 16'hFFFF) cancel_cnt[r.symbol]++;
      end
      ACT_FILL: begin
        t = longint'(traded) + longint'(r.volume);
        if (t < 0) t = 0;
        if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
        traded = t[31:0];
      end
      ACT_TICK: begin
        if (flow_tmr != 16'hFFFF) flow_tmr++;
        if (flow_tmr >= regs.flow_window_ticks) begin
          flow_cnt = '0;
          flow_tmr = '0;
        end
      end
      ACT_DAY: clear_day();
      default: ;
    endcase
    v.accepted = (code == RC_NONE);
    v.reject_code = code;
    verdicts.push_back(v);
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      regs.checks_enabled     = 1'b0;
      regs.max_order_volume   = 31'd100;
      regs.trade_volume_limit = 32'd1000;
      regs.flow_limit         = 16'd50;
      regs.flow_window_ticks  = 16'd1;
      regs.max_active_orders  = 7'd50;
      regs.cancel_limit       = 16'd500;
      regs.self_trade_guard   = 1'b0;
      clear_day();
      verdicts.delete();
      fail_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_ENABLE: regs.checks_enabled     = cfg_pwdata[0];
          REG_SIZE:   regs.max_order_volume   = cfg_pwdata[30:0];
          REG_TRADED: regs.trade_volume_limit = cfg_pwdata;
          REG_FLOW:   regs.flow_limit         = cfg_pwdata[15:0];
          REG_WINDOW: regs.flow_window_ticks  = cfg_pwdata[15:0];
          REG_ACTIVE: regs.max_active_orders  = cfg_pwdata[6:0];
          REG_CANCEL: regs.cancel_limit       = cfg_pwdata[15:0];
          REG_GUARD:  regs.self_trade_guard   = cfg_pwdata[0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (verdicts.size() == 0) begin
          report("result with no request waiting");
        end else begin
          e = verdicts.pop_front();
          if (out_item.accepted !== e.accepted)
            report($sformatf("accepted %b, want %b", out_item.accepted, e.accepted));
          if (out_item.reject_code !== e.reject_code)
            report($sformatf("reject_code %0d, want %0d", out_item.reject_code, e.reject_code));
          if (out_item.was_check !== e.was_check)
            report($sformatf("was_check %b, want %b", out_item.was_check, e.was_check));
        end
      end
      if (in_start && !in_busy) apply_request(in_item);
    end
    pending_count = verdicts.size();
  end
endmodule

>>> tb/pre_trade_risk_checker_tb.sv
// Testbench top of the pre-trade risk checker: clock, reset, request and register stimulus,
// and the verdict. Depends on ptrc_pkg, pre_trade_risk_checker and pre_trade_risk_checker_chk.
`timescale 1ns / 100ps
module pre_trade_risk_checker_tb;
  import ptrc_pkg::*;

  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_start = 1'b0;
  in_item_t    in_item = '0;
  logic        in_busy, out_valid;
  out_item_t   out_item;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count, pending_count;
  int          idle_pct;

  always #5 clk = ~clk;

  pre_trade_risk_checker u_top (.*);
  pre_trade_risk_checker_chk u_chk (.*);

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send(input in_item_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_start <= 1'b0;
      @(posedge clk);
    end
    in_start <= 1'b1;
    in_item <= r;
    @(negedge clk);
    while (in_busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    in_start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic in_item_t mk(input logic [2:0] a, input logic [3:0] s,
                                  input logic [5:0] sl, input logic sd,
                                  input logic [31:0] p, input logic [31:0] v,
                                  input logic lv, input logic cn);
    in_item_t r;
    r.action = a; r.symbol = s; r.order_slot = sl; r.side = sd;
    r.price = p; r.volume = v; r.order_live = lv; r.order_cancelled = cn;
    return r;
  endfunction

  function automatic in_item_t rand_request(input bit wild);
    in_item_t r;
    int k;
    r = '0;
    r.symbol = SYM_W'($urandom_range(3));
    r.order_slot = SLOT_W'($urandom_range(63));
    r.side = 1'($urandom_range(1));
    r.price = $urandom_range(1, 40);
    r.volume = $urandom_range(0, 130) - 10;
    r.order_live = ($urandom_range(3) != 0);
    r.order_cancelled = 1'($urandom_range(1));
    k = $urandom_range(99);
    r.action = k < 45 ? ACT_CHECK : k < 80 ? ACT_UPDATE : k < 90 ? ACT_FILL :
               k < 98 ? ACT_TICK : ACT_DAY;
    if (wild) begin
      r.symbol = SYM_W'($urandom());
      r.price = $urandom();
      r.volume = $urandom();
      r.action = 3'($urandom_range(7));
    end
    return r;
  endfunction

  task automatic set_regs(input logic [31:0] v [8]);
    for (int i = 0; i < 8; i++) write_reg(i[2:0], v[i]);
  endtask

  initial begin
    logic [31:0] setting [8];
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 10;
    send(mk(ACT_CHECK, 0, 0, 0, 5, 10, 0, 0));
    drain();
    setting = '{1, 100, 1000, 50, 3, 50, 500, 1};
    set_regs(setting);
    send(mk(ACT_CHECK, 0, 0, 0, 5, 0, 0, 0));
    send(mk(ACT_CHECK, 0, 0, 0, 5, 32'h8000_0000, 0, 0));
    send(mk(ACT_CHECK, 0, 0, 0, 5, 32'h7FFF_FFFF, 0, 0));
    send(mk(ACT_CHECK, 0, 0, 0, 5, 100, 0, 0));
    send(mk(ACT_UPDATE, 15, 63, 1, 20, 0, 1, 1));
    send(mk(ACT_UPDATE, 15, 62, 1, 0, 0, 1, 0));
    send(mk(ACT_CHECK, 15, 0, 0, 20, 1, 0, 0));
    send(mk(ACT_CHECK, 15, 0, 0, 19, 1, 0, 0));
    send(mk(ACT_UPDATE, 15, 63, 0, 20, 0, 0, 1));
    send(mk(ACT_UPDATE, 15, 61, 0, 32'hFFFF_FFFF, 0, 1, 0));
    send(mk(ACT_CHECK, 15, 0, 1, 32'hFFFF_FFFF, 1, 0, 0));
    send(mk(ACT_FILL, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0));
    send(mk(ACT_FILL, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0));
    send(mk(ACT_FILL, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0));
    send(mk(ACT_CHECK, 1, 0, 0, 1, 1, 0, 0));
    send(mk(ACT_FILL, 0, 0, 0, 0, 32'h8000_0000, 0, 0));
    send(mk(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_SPARE_LO, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_SPARE_HI, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_DAY, 0, 0, 0, 0, 0, 0, 0));
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = ph < 2 ? 10 : ph < 4 ? 45 : 0;
      case (ph)
        0: setting = '{1, 60, 1500, 20, 4, 6, 8, 1};
        1: setting = '{1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0, 64, 16'hFFFF, 1};
        2: setting = '{1, 0, 0, 0, 16'hFFFF, 0, 0, 0};
        3: setting = '{0, 100, 1000, 50, 1, 50, 500, 1};
        4: setting = '{1, 90, 3000, 40, 6, 10, 20, 0};
        default: setting = '{1, 120, 2500, 30, 2, 4, 12, 1};
      endcase
      set_regs(setting);
      for (int n = 0; n < 280; n++) send(rand_request($urandom_range(99) < 10));
      drain();
    end
    if (fail_count == 0 && pending_count == 0)
      $display("pre_trade_risk_checker_tb: done, clean");
    else
      $display("pre_trade_risk_checker_tb: done, errors");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("pre_trade_risk_checker_tb: done, errors");
    $finish;
  end
endmodule
